// ===== design/deque_with_delete_by_value_top_defines.svh =====
// Assertion macros shared by the deque controller and datapath.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef DEQUE_WITH_DELETE_BY_VALUE_TOP_DEFINES_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define DQDEL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds, post holds in the next cycle.
`define DQDEL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define DQDEL_ASSERT(lbl, prop, msg)
`define DQDEL_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== design/dqdel_pkg.sv =====
// Shared types and constants of the deque with delete by value.
// No dependencies.
package dqdel_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK    = 3'd0,
        CMD_POP_BACK     = 3'd1,
        CMD_INSERT_FRONT = 3'd2,
        CMD_TAKE_FRONT   = 3'd3,
        CMD_DELETE       = 3'd4,
        CMD_COUNT        = 3'd5
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic        [2:0]  cmd;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic        [4:0]  item_count;
        logic        [1:0]  status;
    } out_item_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_PUSH,
        DP_INSERT,
        DP_POP,
        DP_TAKE,
        DP_CAPTURE,
        DP_SRCH_START,
        DP_SRCH_NEXT,
        DP_SRCH_HOLD,
        DP_SHIFT_STEP,
        DP_SHIFT_LAST,
        DP_DEL_DONE,
        DP_FAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       empty;
        logic       full;
        logic       match;
        logic       srch_last;
        logic       shift_last;
    } dp_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_SEARCH,
        S_SHIFT,
        S_RESP
    } ctrl_state_t;

endpackage

// ===== design/dqdel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dqdel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/dqdel_ctrl.sv =====
// Command sequencer of the deque: decodes each item and steps the datapath.
// Depends on dqdel_pkg and the assertion macro header.
`include "deque_with_delete_by_value_top_defines.svh"

module dqdel_ctrl
    import dqdel_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = DP_NONE;
        ctrl.code  = ST_OK;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE, S_RESP:
            begin
                busy = 1'b0;
                done = (state_reg == S_RESP);
                if (start)
                begin
                    ctrl.op    = DP_LOAD;
                    state_next = S_DISPATCH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESP;
                unique case (stat.cmd)
                    CMD_PUSH_BACK, CMD_INSERT_FRONT:
                    begin
                        if (stat.full)
                        begin
                            ctrl.op   = DP_FAIL;
                            ctrl.code = ST_FULL;
                        end
                        else
                        begin
                            ctrl.op = (stat.cmd == CMD_PUSH_BACK) ? DP_PUSH : DP_INSERT;
                        end
                    end
                    CMD_POP_BACK, CMD_TAKE_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.op   = DP_FAIL;
                            ctrl.code = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.op    = (stat.cmd == CMD_POP_BACK) ? DP_POP : DP_TAKE;
                            state_next = S_RD_WAIT;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.op   = DP_FAIL;
                            ctrl.code = ST_NOMATCH;
                        end
                        else
                        begin
                            ctrl.op    = DP_SRCH_START;
                            state_next = S_SEARCH;
                        end
                    end
                    default:
                    begin
                        ctrl.op = DP_NONE;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                ctrl.op    = DP_CAPTURE;
                state_next = S_RESP;
            end
            S_SEARCH:
            begin
                if (stat.match)
                begin
                    if (stat.srch_last)
                    begin
                        ctrl.op    = DP_DEL_DONE;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        ctrl.op    = DP_SRCH_HOLD;
                        state_next = S_SHIFT;
                    end
                end
                else if (stat.srch_last)
                begin
                    ctrl.op    = DP_FAIL;
                    ctrl.code  = ST_NOMATCH;
                    state_next = S_RESP;
                end
                else
                begin
                    ctrl.op = DP_SRCH_NEXT;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_last)
                begin
                    ctrl.op    = DP_SHIFT_LAST;
                    state_next = S_RESP;
                end
                else
                begin
                    ctrl.op = DP_SHIFT_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `DQDEL_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
    `DQDEL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accepting an item")
    `DQDEL_ASSERT_NEXT(a_shift_entry, state_reg != S_SEARCH && state_reg != S_SHIFT,
        state_reg != S_SHIFT, "compaction entered without a search match")

endmodule

// ===== design/dqdel_dp.sv =====
// Datapath of the deque: circular entry store, front index, count and result registers.
// Depends on dqdel_pkg, dqdel_ram and the assertion macro header.
`include "deque_with_delete_by_value_top_defines.svh"

module dqdel_dp
    import dqdel_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  request,
    input  dp_ctrl_t  ctrl,
    output dp_stat_t  stat,
    output out_item_t result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0]      front_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [2:0]            cmd_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [31:0]           rd_reg;
    status_t               status_reg;

    logic [63:0]           value_ext;
    logic [DATA_WIDTH-1:0] word_in;
    logic [IDX_W-1:0]      front_dec;
    logic [CNT_W-1:0]      rd_off;
    logic                  re;
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata;

    // Position of the entry at a given offset from the front, wrapped once.
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] front,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign value_ext = {{32{request.value[31]}}, request.value};
    assign word_in   = value_ext[DATA_WIDTH-1:0];
    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - IDX_W'(1);

    always_comb
    begin
        rd_off = '0;
        re     = 1'b1;
        case (ctrl.op) inside
            DP_POP:                     rd_off = count_reg - CNT_W'(1);
            DP_TAKE, DP_SRCH_START:     rd_off = '0;
            DP_SRCH_NEXT, DP_SRCH_HOLD: rd_off = idx_reg + CNT_W'(1);
            DP_SHIFT_STEP:              rd_off = idx_reg + CNT_W'(2);
            default:                    re = 1'b0;
        endcase
    end

    always_comb
    begin
        we    = 1'b1;
        waddr = slot(front_reg, idx_reg);
        wdata = rdata;
        case (ctrl.op) inside
            DP_PUSH:
            begin
                waddr = slot(front_reg, count_reg);
                wdata = word_reg;
            end
            DP_INSERT:
            begin
                waddr = front_dec;
                wdata = word_reg;
            end
            DP_SHIFT_STEP, DP_SHIFT_LAST:
            begin
                waddr = slot(front_reg, idx_reg);
                wdata = rdata;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    dqdel_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(slot(front_reg, rd_off)),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (ctrl.op) inside
                DP_PUSH:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                DP_INSERT:
                begin
                    front_reg <= front_dec;
                    count_reg <= count_reg + CNT_W'(1);
                end
                DP_TAKE:
                begin
                    front_reg <= slot(front_reg, CNT_W'(1));
                    count_reg <= count_reg - CNT_W'(1);
                end
                DP_POP, DP_SHIFT_LAST, DP_DEL_DONE:
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op) inside
            DP_LOAD:
            begin
                cmd_reg    <= request.cmd;
                word_reg   <= word_in;
                rd_reg     <= '0;
                status_reg <= ST_OK;
            end
            DP_CAPTURE:
            begin
                // zero-extend a narrow entry, keep the low word of a wide one
                rd_reg <= 32'(64'(rdata));
            end
            DP_SRCH_START:
            begin
                idx_reg <= '0;
            end
            DP_SRCH_NEXT, DP_SHIFT_STEP:
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            DP_FAIL:
            begin
                status_reg <= ctrl.code;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.cmd        = cmd_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.match      = (rdata == word_reg);
    assign stat.srch_last  = (SUM_W'(idx_reg) + SUM_W'(1)) >= SUM_W'(count_reg);
    assign stat.shift_last = (SUM_W'(idx_reg) + SUM_W'(2)) >= SUM_W'(count_reg);

    assign result.read_data  = rd_reg;
    assign result.item_count = 5'(count_reg);
    assign result.status     = status_reg;

    `DQDEL_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `DQDEL_ASSERT_NEXT(a_push_count, ctrl.op == DP_PUSH || ctrl.op == DP_INSERT,
        count_reg == CNT_W'($past(count_reg) + 1'b1), "insertion did not raise the count")

endmodule

// ===== design/deque_with_delete_by_value_top.sv =====
// Bounded double-ended queue with delete by value: top level.
// A start with busy low is accepted; each item gives exactly one result, shown on result for
// one cycle while done is high, and it cannot be held off. Push, insert, count and any refused
// command pass through the dispatch state to the response state; pop and take also pass the
// read-wait state, for the registered read of the entry store. Delete walks the store one
// entry per cycle through its single read port. A new item may be accepted in the cycle in
// which done is high. No clearing pass runs after reset.
// Depends on dqdel_pkg, dqdel_ctrl and dqdel_dp.
module deque_with_delete_by_value_top
    import dqdel_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  request,
    output logic      done,
    output out_item_t result
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    dqdel_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .done (done),
        .stat (stat),
        .ctrl (ctrl)
    );

    dqdel_dp #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .ctrl   (ctrl),
        .stat   (stat),
        .result (result)
    );

endmodule
